### design/bdq_pkg.sv
// Shared types and constants for the bounded deque with search.
// No dependencies; used by bdq_store and bounded_deque_with_search_core.
package bdq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 4;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_FIND       = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

### design/bdq_store.sv
// Element ring storage: one write port, one registered read port and key compare.
// Depends on bdq_pkg for the data width.
module bdq_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]              wr_addr_i,
  input  logic signed [bdq_pkg::DataW-1:0]      wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]              rd_addr_i,
  input  logic signed [bdq_pkg::DataW-1:0]      key_i,
  output logic                                  hit_o
);

  logic signed [bdq_pkg::DataW-1:0] mem_q [DEPTH];
  logic signed [bdq_pkg::DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // compare against the entry read last cycle
  assign hit_o = (rd_data_q == key_i);

endmodule

### design/bounded_deque_with_search_core.sv
// Bounded deque of signed 32-bit values in a ring memory, with front-to-back search.
// Push and pop: result strobe in the cycle after the request beat; next request that cycle.
// Find: the request beat reads the front entry, then one memory read and compare per entry
// walked until a match or the last stored entry; done_o then strobes the result.
// Reset (async, active low) empties the deque; memory contents are left as they are.
// Results cannot be stalled: done_o marks each result for exactly one cycle.
module bounded_deque_with_search_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [2:0]                             action_i,
  input  logic signed [bdq_pkg::DataW-1:0]       value_i,
  output logic                                   done_o,
  output logic [1:0]                             status_o,
  output logic [bdq_pkg::PosW-1:0]               position_o,
  output logic [$clog2(DEPTH+1)-1:0]             fill_count_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                            state_q, state_d;
  logic [IdxW-1:0]                   front_q, front_d;
  logic [CntW-1:0]                   count_q, count_d;
  logic [IdxW-1:0]                   rd_ptr_q, rd_ptr_d;
  logic [IdxW-1:0]                   cmp_pos_q, cmp_pos_d;
  logic signed [bdq_pkg::DataW-1:0]  key_q, key_d;
  logic                              done_q, done_d;
  bdq_pkg::status_e                  status_q, status_d;
  logic [bdq_pkg::PosW-1:0]          pos_q, pos_d;

  logic                              accept;
  logic                              wr_en;
  logic [IdxW-1:0]                   wr_addr;
  logic                              rd_en;
  logic [IdxW-1:0]                   rd_addr;
  logic                              hit;
  logic [CntW:0]                     back_sum;
  logic [IdxW-1:0]                   back_addr;
  logic                              is_full;
  logic                              is_empty;

  function automatic logic [IdxW-1:0] ring_inc(input logic [IdxW-1:0] idx);
    ring_inc = (idx == IdxW'(DEPTH - 1)) ? '0 : idx + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] ring_dec(input logic [IdxW-1:0] idx);
    ring_dec = (idx == '0) ? IdxW'(DEPTH - 1) : idx - IdxW'(1);
  endfunction

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  // front + count stays below 2*DEPTH, so one conditional subtract wraps it
  assign back_sum  = (CntW+1)'(front_q) + (CntW+1)'(count_q);
  assign back_addr = (back_sum >= (CntW+1)'(DEPTH)) ?
                     IdxW'(back_sum - (CntW+1)'(DEPTH)) : IdxW'(back_sum);

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    rd_ptr_d  = rd_ptr_q;
    cmp_pos_d = cmp_pos_q;
    key_d     = key_q;
    done_d    = 1'b0;
    status_d  = status_q;
    pos_d     = pos_q;
    wr_en     = 1'b0;
    wr_addr   = back_addr;
    rd_en     = 1'b0;
    rd_addr   = rd_ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d   = 1'b1;
          status_d = bdq_pkg::ST_OK;
          pos_d    = '0;
          case (bdq_pkg::action_e'(action_i))
            bdq_pkg::ACT_PUSH_BACK: begin
              if (is_full) begin
                status_d = bdq_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = back_addr;
                count_d = count_q + CntW'(1);
              end
            end
            bdq_pkg::ACT_PUSH_FRONT: begin
              if (is_full) begin
                status_d = bdq_pkg::ST_FULL;
              end else begin
                front_d = ring_dec(front_q);
                wr_en   = 1'b1;
                wr_addr = ring_dec(front_q);
                count_d = count_q + CntW'(1);
              end
            end
            bdq_pkg::ACT_POP_BACK: begin
              if (is_empty) begin
                status_d = bdq_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
              end
            end
            bdq_pkg::ACT_POP_FRONT: begin
              if (is_empty) begin
                status_d = bdq_pkg::ST_EMPTY;
              end else begin
                front_d = ring_inc(front_q);
                count_d = count_q - CntW'(1);
              end
            end
            bdq_pkg::ACT_FIND: begin
              if (is_empty) begin
                status_d = bdq_pkg::ST_NOT_FOUND;
              end else begin
                // launch the read of the front entry; result comes from the scan
                done_d    = 1'b0;
                rd_en     = 1'b1;
                rd_addr   = front_q;
                rd_ptr_d  = ring_inc(front_q);
                cmp_pos_d = '0;
                key_d     = value_i;
                state_d   = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          done_d   = 1'b1;
          status_d = bdq_pkg::ST_OK;
          pos_d    = bdq_pkg::PosW'(cmp_pos_q);
          state_d  = S_IDLE;
        end else if (CntW'(cmp_pos_q) == count_q - CntW'(1)) begin
          done_d   = 1'b1;
          status_d = bdq_pkg::ST_NOT_FOUND;
          pos_d    = '0;
          state_d  = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = rd_ptr_q;
          rd_ptr_d  = ring_inc(rd_ptr_q);
          cmp_pos_d = cmp_pos_q + IdxW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      rd_ptr_q  <= '0;
      cmp_pos_q <= '0;
      key_q     <= '0;
      done_q    <= 1'b0;
      status_q  <= bdq_pkg::ST_OK;
      pos_q     <= '0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      rd_ptr_q  <= rd_ptr_d;
      cmp_pos_q <= cmp_pos_d;
      key_q     <= key_d;
      done_q    <= done_d;
      status_q  <= status_d;
      pos_q     <= pos_d;
    end
  end

  bdq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .key_i     (key_q),
    .hit_o     (hit)
  );

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign position_o   = pos_q;
  assign fill_count_o = count_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("element count above depth");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (count_q != '0) && (CntW'(cmp_pos_q) < count_q))
    else $error("scan position outside stored range");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i != bdq_pkg::ACT_FIND) |=> done_q && (state_q == S_IDLE))
    else $error("push/pop result not returned next cycle");

  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (status_q == bdq_pkg::ST_FULL) |-> (count_q == CntW'(DEPTH)))
    else $error("full status with room left");

  a_scan_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !done_q)
    else $error("result strobed on scan start");
`endif

endmodule
